@@ rtl/heightmap_triangle_height_sampler_core_assert.svh @@
// Assertion macros for the height sampler core
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_CORE_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HTS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("height sampler check failed");

// antecedent implies consequent in the next cycle
`define HTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("height sampler check failed");

`endif

@@ rtl/hts_pkg.sv @@
`default_nettype none
package hts_pkg;
    localparam int MAX_SIDE_DEFAULT = 256;
    localparam int CSW = 31;

    localparam logic [2:0] CFG_CELL_SIZE     = 3'd0;
    localparam logic [2:0] CFG_HEIGHT_SCALE  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT_OFFSET = 3'd2;
    localparam logic [2:0] CFG_GRID_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_GRID_HEIGHT   = 3'd4;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CSW-1:0]    CELL_SIZE_RST = 31'd65536;
    localparam logic signed [31:0] SCALE_RST    = 32'sd65536;
    localparam logic signed [31:0] OFFSET_RST   = 32'sd0;
    localparam logic [8:0]        SIDE_RST      = 9'd256;

    typedef struct packed {
        logic        mode;
        logic [15:0] addr;
        logic [7:0]  value;
        logic        sx;
    } front_tag_t;

    typedef struct packed {
        logic               sp;
        logic signed [40:0] sq;
        logic               oor;
    } back_tag_t;
endpackage
`default_nettype wire

@@ rtl/hts_div.sv @@
`default_nettype none
module hts_div #(
    parameter int NQ = 32,
    parameter int TW = 1
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [hts_pkg::CSW-1:0] in_hi,
    input  wire logic [NQ-1:0]           in_lo,
    input  wire logic [TW-1:0]           in_tag,
    input  wire logic [hts_pkg::CSW-1:0] divisor,
    output logic                         out_valid,
    output logic [NQ-1:0]                out_q,
    output logic [hts_pkg::CSW-1:0]      out_r,
    output logic [TW-1:0]                out_tag
);
    localparam int RW = hts_pkg::CSW;

    logic          v_reg   [NQ];
    logic [RW-1:0] rem_reg [NQ];
    logic [NQ-1:0] lo_reg  [NQ];
    logic [TW-1:0] tag_reg [NQ];

    for (genvar k = 0; k < NQ; k++) begin : g_step
        logic          v_src;
        logic [RW-1:0] rem_src;
        logic [NQ-1:0] lo_src;
        logic [TW-1:0] tag_src;
        logic [RW:0]   shifted;
        logic [RW:0]   diff;
        logic          take;

        if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign rem_src = in_hi;
            assign lo_src  = in_lo;
            assign tag_src = in_tag;
        end else begin : g_rest
            assign v_src   = v_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign lo_src  = lo_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        assign shifted = {rem_src, lo_src[NQ-1]};
        assign diff    = shifted - {1'b0, divisor};
        assign take    = shifted >= {1'b0, divisor};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? diff[RW-1:0] : shifted[RW-1:0];
                lo_reg[k]  <= {lo_src[NQ-2:0], take};
                tag_reg[k] <= tag_src;
            end
        end
    end

    assign out_valid = v_reg[NQ-1];
    assign out_q     = lo_reg[NQ-1];
    assign out_r     = rem_reg[NQ-1];
    assign out_tag   = tag_reg[NQ-1];
endmodule
`default_nettype wire

@@ rtl/hts_grid.sv @@
`default_nettype none
module hts_grid #(
    parameter int MAX_SIDE = hts_pkg::MAX_SIDE_DEFAULT,
    localparam int DEPTH = MAX_SIDE * MAX_SIDE,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] ra1,
    input  wire logic [AW-1:0] ra4,
    input  wire logic [AW-1:0] ram,
    output logic [7:0]         rd1,
    output logic [7:0]         rd4,
    output logic [7:0]         rdm
);
    logic [7:0] mem_a [DEPTH];
    logic [7:0] mem_b [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_a[waddr] <= wdata;
            mem_b[waddr] <= wdata;
        end
        if (re) begin
            rd1 <= mem_a[ra1];
            rd4 <= mem_a[ra4];
            rdm <= mem_b[ram];
        end
    end
endmodule
`default_nettype wire

@@ rtl/heightmap_triangle_height_sampler_core.sv @@
// Throughput: one word per cycle, writes and queries alike, while m_tready is
// high or the output register is empty; four pipelined dividers (32, 32, 8 and
// 31 steps; the first two run side by side) and a grid kept in two copies (two
// reads on one, one read on the other) carry a query every cycle when unstalled.
// Reset: clears pipeline valid bits and sets the configuration to its defaults;
// grid memory keeps its contents and needs no clearing pass.
`default_nettype none
`include "heightmap_triangle_height_sampler_core_assert.svh"
module heightmap_triangle_height_sampler_core #(
    parameter int MAX_SIDE = hts_pkg::MAX_SIDE_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // sample_addr, sample_value, query_x, query_z
    input  wire logic [0:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // height
    output logic [0:0]       m_tuser,   // out_of_range
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = AW + 2;
    localparam int XW = $clog2(MAX_SIDE);
    localparam int GW = $clog2(MAX_SIDE + 1);
    localparam int CSW = hts_pkg::CSW;

    function automatic logic [GW-1:0] clamp_side(input logic [8:0] s);
        if (s < 9'd2) return GW'(2);
        if (32'(s) > MAX_SIDE) return GW'(MAX_SIDE);
        return GW'(s);
    endfunction

    function automatic logic signed [34:0] floor_q(input logic neg, input logic [31:0] q,
                                                  input logic [CSW-1:0] r);
        logic signed [34:0] qs;
        qs = signed'(35'(q));
        if (!neg) return qs;
        if (r != '0) return -qs - 35'sd1;
        return -qs;
    endfunction

    function automatic logic [CSW-1:0] floor_r(input logic neg, input logic [CSW-1:0] r,
                                               input logic [CSW-1:0] d);
        if (neg && r != '0) return d - r;
        return r;
    endfunction

    // configuration
    logic [CSW-1:0]     cs_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] offset_reg;
    logic [GW-1:0]      gw_reg;
    logic [GW-1:0]      gh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg     <= hts_pkg::CELL_SIZE_RST;
            scale_reg  <= hts_pkg::SCALE_RST;
            offset_reg <= hts_pkg::OFFSET_RST;
            gw_reg     <= clamp_side(hts_pkg::SIDE_RST);
            gh_reg     <= clamp_side(hts_pkg::SIDE_RST);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hts_pkg::CFG_CELL_SIZE: begin
                    cs_reg <= (cfg_data[CSW-1:0] == '0) ? CSW'(1) : cfg_data[CSW-1:0];
                end
                hts_pkg::CFG_HEIGHT_SCALE:  scale_reg  <= signed'(cfg_data);
                hts_pkg::CFG_HEIGHT_OFFSET: offset_reg <= signed'(cfg_data);
                hts_pkg::CFG_GRID_WIDTH:    gw_reg     <= clamp_side(cfg_data[8:0]);
                hts_pkg::CFG_GRID_HEIGHT:   gh_reg     <= clamp_side(cfg_data[8:0]);
                default: ;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;
    logic [31:0] m_data_reg;
    logic [0:0]  m_tuser_reg;

    assign adv = !m_valid_reg || m_tready;

    // stage A: input register
    logic        v_a_reg;
    logic        mode_a_reg;
    logic [15:0] addr_a_reg;
    logic [7:0]  value_a_reg;
    logic        sx_a_reg;
    logic        sz_a_reg;
    logic [31:0] ax_a_reg;
    logic [31:0] az_a_reg;
    logic [31:0] qx_in;
    logic [31:0] qz_in;

    assign s_tready = adv || !v_a_reg;
    assign qx_in = s_tdata[55:24];
    assign qz_in = s_tdata[87:56];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
        end else if (s_tready) begin
            v_a_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            mode_a_reg  <= s_tuser[0];
            addr_a_reg  <= s_tdata[15:0];
            value_a_reg <= s_tdata[23:16];
            sx_a_reg    <= qx_in[31];
            sz_a_reg    <= qz_in[31];
            ax_a_reg    <= qx_in[31] ? (32'd0 - qx_in) : qx_in;
            az_a_reg    <= qz_in[31] ? (32'd0 - qz_in) : qz_in;
        end
    end

    // cell index division
    hts_pkg::front_tag_t tag_a;
    hts_pkg::front_tag_t tag_x;
    logic                v_x;
    logic [31:0]         q_x;
    logic [CSW-1:0]      r_x;
    logic                v_z;
    logic [31:0]         q_z;
    logic [CSW-1:0]      r_z;
    logic                sz_z;

    assign tag_a.mode  = mode_a_reg;
    assign tag_a.addr  = addr_a_reg;
    assign tag_a.value = value_a_reg;
    assign tag_a.sx    = sx_a_reg;

    hts_div #(.NQ(32), .TW($bits(hts_pkg::front_tag_t))) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v_a_reg),
        .in_hi     ('0),
        .in_lo     (ax_a_reg),
        .in_tag    (tag_a),
        .divisor   (cs_reg),
        .out_valid (v_x),
        .out_q     (q_x),
        .out_r     (r_x),
        .out_tag   (tag_x)
    );

    hts_div #(.NQ(32), .TW(1)) u_div_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v_a_reg),
        .in_hi     ('0),
        .in_lo     (az_a_reg),
        .in_tag    (sz_a_reg),
        .divisor   (cs_reg),
        .out_valid (v_z),
        .out_q     (q_z),
        .out_r     (r_z),
        .out_tag   (sz_z)
    );

    // stage B: floor correction
    logic                v_b_reg;
    hts_pkg::front_tag_t tag_b_reg;
    logic signed [34:0]  cx_b_reg;
    logic signed [34:0]  cz_b_reg;
    logic [CSW-1:0]      fx_b_reg;
    logic [CSW-1:0]      fz_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_b_reg <= 1'b0;
        end else if (adv) begin
            v_b_reg <= v_x && v_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_b_reg <= tag_x;
            cx_b_reg  <= floor_q(tag_x.sx, q_x, r_x);
            cz_b_reg  <= floor_q(sz_z, q_z, r_z);
            fx_b_reg  <= floor_r(tag_x.sx, r_x, cs_reg);
            fz_b_reg  <= floor_r(sz_z, r_z, cs_reg);
        end
    end

    // stage C: centre and bounds check
    logic signed [34:0] col_c;
    logic signed [34:0] row_c;
    logic signed [34:0] gw_lim;
    logic signed [34:0] gh_lim;
    logic               oor_c;
    logic [AW+15:0]     wa_ext;

    assign col_c  = cx_b_reg + 35'(gw_reg >> 1);
    assign row_c  = cz_b_reg + 35'(gh_reg >> 1);
    assign gw_lim = 35'(gw_reg) - 35'd2;
    assign gh_lim = 35'(gh_reg) - 35'd2;
    assign oor_c  = (col_c < 0) || (col_c > gw_lim) || (row_c < 0) || (row_c > gh_lim);
    assign wa_ext = {{AW{1'b0}}, tag_b_reg.addr};

    logic           v_c_reg;
    logic           mode_c_reg;
    logic           oor_c_reg;
    logic [XW-1:0]  col_c_reg;
    logic [XW-1:0]  row_c_reg;
    logic [CSW-1:0] fx_c_reg;
    logic [CSW-1:0] fz_c_reg;
    logic [AW-1:0]  waddr_c_reg;
    logic           wok_c_reg;
    logic [7:0]     value_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg <= 1'b0;
        end else if (adv) begin
            v_c_reg <= v_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode_c_reg  <= tag_b_reg.mode;
            oor_c_reg   <= oor_c;
            col_c_reg   <= col_c[XW-1:0];
            row_c_reg   <= row_c[XW-1:0];
            fx_c_reg    <= fx_b_reg;
            fz_c_reg    <= fz_b_reg;
            waddr_c_reg <= wa_ext[AW-1:0];
            wok_c_reg   <= wa_ext < (AW+16)'(DEPTH);
            value_c_reg <= tag_b_reg.value;
        end
    end

    // stage D: addresses, triangle select, weights
    logic [LW-1:0] a1_c;
    logic          upper_sel;

    assign a1_c      = LW'(row_c_reg) * LW'(gw_reg) + LW'(col_c_reg);
    assign upper_sel = fx_c_reg > fz_c_reg;

    logic           v_d_reg;
    logic           mode_d_reg;
    logic           oor_d_reg;
    logic [AW-1:0]  a1_d_reg;
    logic [AW-1:0]  a4_d_reg;
    logic [AW-1:0]  am_d_reg;
    logic [CSW-1:0] w1_d_reg;
    logic [CSW-1:0] wm_d_reg;
    logic [CSW-1:0] w4_d_reg;
    logic [AW-1:0]  waddr_d_reg;
    logic           wok_d_reg;
    logic [7:0]     value_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_d_reg <= 1'b0;
        end else if (adv) begin
            v_d_reg <= v_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode_d_reg  <= mode_c_reg;
            oor_d_reg   <= oor_c_reg;
            a1_d_reg    <= a1_c[AW-1:0];
            a4_d_reg    <= AW'(a1_c + LW'(gw_reg) + LW'(1));
            am_d_reg    <= upper_sel ? AW'(a1_c + LW'(1)) : AW'(a1_c + LW'(gw_reg));
            w1_d_reg    <= upper_sel ? (cs_reg - fx_c_reg) : (cs_reg - fz_c_reg);
            wm_d_reg    <= upper_sel ? (fx_c_reg - fz_c_reg) : (fz_c_reg - fx_c_reg);
            w4_d_reg    <= upper_sel ? fz_c_reg : fx_c_reg;
            waddr_d_reg <= waddr_c_reg;
            wok_d_reg   <= wok_c_reg;
            value_d_reg <= value_c_reg;
        end
    end

    // grid memory access
    logic       grid_we;
    logic       grid_re;
    logic [7:0] rd1;
    logic [7:0] rd4;
    logic [7:0] rdm;

    assign grid_we = adv && v_d_reg && (mode_d_reg == hts_pkg::MODE_WRITE) && wok_d_reg;
    assign grid_re = adv && v_d_reg && (mode_d_reg == hts_pkg::MODE_QUERY) && !oor_d_reg;

    hts_grid #(.MAX_SIDE(MAX_SIDE)) u_grid (
        .aclk  (aclk),
        .we    (grid_we),
        .waddr (waddr_d_reg),
        .wdata (value_d_reg),
        .re    (grid_re),
        .ra1   (a1_d_reg),
        .ra4   (a4_d_reg),
        .ram   (am_d_reg),
        .rd1   (rd1),
        .rd4   (rd4),
        .rdm   (rdm)
    );

    // stage E: samples arrive; write words drop out here
    logic           v_e_reg;
    logic           oor_e_reg;
    logic [CSW-1:0] w1_e_reg;
    logic [CSW-1:0] wm_e_reg;
    logic [CSW-1:0] w4_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_e_reg <= 1'b0;
        end else if (adv) begin
            v_e_reg <= v_d_reg && (mode_d_reg == hts_pkg::MODE_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            oor_e_reg <= oor_d_reg;
            w1_e_reg  <= w1_d_reg;
            wm_e_reg  <= wm_d_reg;
            w4_e_reg  <= w4_d_reg;
        end
    end

    // stage F: weighted sum
    logic        v_f_reg;
    logic        oor_f_reg;
    logic [38:0] n_f_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_f_reg <= 1'b0;
        end else if (adv) begin
            v_f_reg <= v_e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            oor_f_reg <= oor_e_reg;
            n_f_reg   <= 39'(rd1) * 39'(w1_e_reg) + 39'(rdm) * 39'(wm_e_reg)
                       + 39'(rd4) * 39'(w4_e_reg);
        end
    end

    // split the sum into whole cells and remainder
    logic           v_2;
    logic [7:0]     q_2;
    logic [CSW-1:0] r_2;
    logic           oor_2;

    hts_div #(.NQ(8), .TW(1)) u_div_n (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v_f_reg),
        .in_hi     (n_f_reg[38:8]),
        .in_lo     (n_f_reg[7:0]),
        .in_tag    (oor_f_reg),
        .divisor   (cs_reg),
        .out_valid (v_2),
        .out_q     (q_2),
        .out_r     (r_2),
        .out_tag   (oor_2)
    );

    // stage G: scale products
    logic               v_g_reg;
    logic               oor_g_reg;
    logic signed [63:0] p_g_reg;
    logic signed [40:0] sq_g_reg;
    logic signed [63:0] p_g;
    logic signed [40:0] sq_g;

    assign p_g  = 64'(scale_reg) * 64'($signed({1'b0, r_2}));
    assign sq_g = 41'(scale_reg) * 41'($signed({1'b0, q_2}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_g_reg <= 1'b0;
        end else if (adv) begin
            v_g_reg <= v_2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            oor_g_reg <= oor_2;
            p_g_reg   <= p_g;
            sq_g_reg  <= sq_g;
        end
    end

    // stage H: magnitude of the fractional product
    logic               v_h_reg;
    hts_pkg::back_tag_t tag_h_reg;
    logic [61:0]        absp_h_reg;
    logic [63:0]        absp_g;

    assign absp_g = p_g_reg[63] ? (64'd0 - p_g_reg) : p_g_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_h_reg <= 1'b0;
        end else if (adv) begin
            v_h_reg <= v_g_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_h_reg.sp  <= p_g_reg[63];
            tag_h_reg.sq  <= sq_g_reg;
            tag_h_reg.oor <= oor_g_reg;
            absp_h_reg    <= absp_g[61:0];
        end
    end

    logic               v_3;
    logic [30:0]        q_3;
    logic [CSW-1:0]     r_3;
    hts_pkg::back_tag_t tag_3;

    hts_div #(.NQ(31), .TW($bits(hts_pkg::back_tag_t))) u_div_p (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v_h_reg),
        .in_hi     (absp_h_reg[61:31]),
        .in_lo     (absp_h_reg[30:0]),
        .in_tag    (tag_h_reg),
        .divisor   (cs_reg),
        .out_valid (v_3),
        .out_q     (q_3),
        .out_r     (r_3),
        .out_tag   (tag_3)
    );

    // stage I: floor of the fractional part
    logic               v_i_reg;
    logic               oor_i_reg;
    logic signed [40:0] sq_i_reg;
    logic signed [32:0] fl_i_reg;
    logic signed [32:0] q3_s;

    assign q3_s = signed'(33'(q_3));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_i_reg <= 1'b0;
        end else if (adv) begin
            v_i_reg <= v_3;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            oor_i_reg <= tag_3.oor;
            sq_i_reg  <= tag_3.sq;
            if (!tag_3.sp) begin
                fl_i_reg <= q3_s;
            end else if (r_3 != '0) begin
                fl_i_reg <= -q3_s - 33'sd1;
            end else begin
                fl_i_reg <= -q3_s;
            end
        end
    end

    // stage J: offset, saturate, output register
    logic signed [42:0] h_sum;
    logic [31:0]        h_sat;

    assign h_sum = 43'(sq_i_reg) + 43'(fl_i_reg) + 43'(offset_reg);

    always_comb begin
        if (h_sum > 43'sd2147483647) begin
            h_sat = 32'h7FFF_FFFF;
        end else if (h_sum < -43'sd2147483648) begin
            h_sat = 32'h8000_0000;
        end else begin
            h_sat = h_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_i_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg  <= oor_i_reg ? 32'd0 : h_sat;
            m_tuser_reg <= oor_i_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_tuser_reg;

    `HTS_ASSERT_IMPLY(a_oor_zero, aclk, aresetn, m_valid_reg && m_tuser_reg[0], m_data_reg == 32'd0)
    `HTS_ASSERT_NEXT(a_hold_input, aclk, aresetn, s_tvalid && s_tready && !adv, v_a_reg)
    `HTS_ASSERT_NEXT(a_write_drops, aclk, aresetn, adv && v_d_reg && mode_d_reg == hts_pkg::MODE_WRITE, !v_e_reg)
endmodule
`default_nettype wire
